### src/universal_code_codec_defines.svh
// Assertion macros for the universal code codec.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef UNIVERSAL_CODE_CODEC_DEFINES_SVH
`define UNIVERSAL_CODE_CODEC_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define UCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low
`define UCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define UCC_ASSERT_NOW(lbl, ante, cons)
`define UCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/ucc_pkg.sv
// Shared types, register indexes and code tables for the universal code codec.
// No dependencies.
package ucc_pkg;

  // Code selection held in the code_kind register
  typedef enum logic [1:0] {
    KIND_UNARY  = 2'd0,
    KIND_BINARY = 2'd1,
    KIND_GAMMA  = 2'd2,
    KIND_FIB    = 2'd3
  } code_kind_t;

  // Configuration register indexes
  localparam logic CFG_CODE_KIND   = 1'b0;
  localparam logic CFG_DECODE_MODE = 1'b1;

  localparam int unsigned CW_W = 15;  // longest codeword (unary 15)

  // One codeword, first bit to send in the top position
  typedef struct packed {
    logic [CW_W-1:0] bits;
    logic [3:0]      len;
  } codeword_t;

  // One encoded bit leaving the serializer
  typedef struct packed {
    logic code_bit;
    logic last;
    logic err;
  } enc_word_t;

  // One decode result
  typedef struct packed {
    logic       valid;
    logic [3:0] symbol;
    logic       err;
  } dec_result_t;

  // C1 codeword per symbol, bits in send order (MSB of the 7-bit field first)
  function automatic codeword_t fib_codeword(input logic [3:0] s);
    logic [6:0] cw;
    logic [3:0] len;
    cw  = '0;
    len = 4'd0;
    unique case (s)
      4'd1:  begin cw = 7'b1100000; len = 4'd2; end
      4'd2:  begin cw = 7'b0110000; len = 4'd3; end
      4'd3:  begin cw = 7'b0011000; len = 4'd4; end
      4'd4:  begin cw = 7'b1011000; len = 4'd4; end
      4'd5:  begin cw = 7'b0001100; len = 4'd5; end
      4'd6:  begin cw = 7'b1001100; len = 4'd5; end
      4'd7:  begin cw = 7'b0101100; len = 4'd5; end
      4'd8:  begin cw = 7'b0000110; len = 4'd6; end
      4'd9:  begin cw = 7'b1000110; len = 4'd6; end
      4'd10: begin cw = 7'b0100110; len = 4'd6; end
      4'd11: begin cw = 7'b0010110; len = 4'd6; end
      4'd12: begin cw = 7'b1010110; len = 4'd6; end
      4'd13: begin cw = 7'b0000011; len = 4'd7; end
      4'd14: begin cw = 7'b1000011; len = 4'd7; end
      4'd15: begin cw = 7'b0100011; len = 4'd7; end
      default: begin cw = 7'b0000000; len = 4'd1; end
    endcase
    return '{bits: {cw, 8'b0}, len: len};
  endfunction

  // Zeckendorf value of gathered C1 bits, weights 1,2,3,5,8,13 from bit 0
  function automatic logic [5:0] fib_value(input logic [5:0] b);
    logic [5:0] v;
    v = 6'd0;
    if (b[0]) v = v + 6'd1;
    if (b[1]) v = v + 6'd2;
    if (b[2]) v = v + 6'd3;
    if (b[3]) v = v + 6'd5;
    if (b[4]) v = v + 6'd8;
    if (b[5]) v = v + 6'd13;
    return v;
  endfunction

endpackage

### src/ucc_encoder.sv
// Codeword serializer: a codeword per symbol, out a bit a cycle while advance is high.
// Depends on ucc_pkg and universal_code_codec_defines.svh.
`include "universal_code_codec_defines.svh"
module ucc_encoder
  import ucc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  code_kind_t code_kind,
  input  logic       load,
  input  logic [3:0] symbol,
  input  logic       advance,
  output logic       busy,
  output enc_word_t  word
);

  logic [CW_W-1:0] shift_r, shift_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic            err_r, err_nxt;
  logic            busy_r, busy_nxt;
  codeword_t       cw;

  // Build the codeword for the arriving symbol
  always_comb begin
    cw = '{bits: '0, len: 4'd1};
    unique case (code_kind)
      KIND_UNARY: begin
        cw.bits = ~({CW_W{1'b1}} >> (symbol - 4'd1));
        cw.len  = symbol;
      end
      KIND_BINARY: begin
        cw.bits = {symbol, {(CW_W-4){1'b0}}};
        cw.len  = 4'd4;
      end
      KIND_GAMMA: begin
        priority if (symbol[3]) begin
          cw.bits = CW_W'(symbol) << 8;
          cw.len  = 4'd7;
        end else if (symbol[2]) begin
          cw.bits = CW_W'(symbol) << 10;
          cw.len  = 4'd5;
        end else if (symbol[1]) begin
          cw.bits = CW_W'(symbol) << 12;
          cw.len  = 4'd3;
        end else begin
          cw.bits = CW_W'(symbol) << 14;
          cw.len  = 4'd1;
        end
      end
      KIND_FIB: cw = fib_codeword(symbol);
      default: cw = '{bits: '0, len: 4'd1};
    endcase
  end

  // Load on a new symbol, shift on each taken bit
  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    busy_nxt  = busy_r;
    if (load) begin
      busy_nxt = 1'b1;
      if (symbol == 4'd0) begin
        shift_nxt = '0;
        cnt_nxt   = 4'd1;
        err_nxt   = 1'b1;
      end else begin
        shift_nxt = cw.bits;
        cnt_nxt   = cw.len;
        err_nxt   = 1'b0;
      end
    end else if (busy_r && advance) begin
      shift_nxt = {shift_r[CW_W-2:0], 1'b0};
      cnt_nxt   = cnt_r - 4'd1;
      if (cnt_r == 4'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    shift_r <= shift_nxt;
    err_r   <= err_nxt;
  end

  assign busy          = busy_r;
  assign word.code_bit = shift_r[CW_W-1];
  assign word.last     = (cnt_r == 4'd1);
  assign word.err      = err_r;

  `UCC_ASSERT_NOW(a_busy_has_bits, busy_r, cnt_r != 4'd0)
  `UCC_ASSERT_NOW(a_err_single, busy_r && err_r, cnt_r == 4'd1 && !shift_r[CW_W-1])
  `UCC_ASSERT_NEXT(a_last_frees, busy_r && advance && cnt_r == 4'd1 && !load, !busy_r)

endmodule

### src/ucc_decoder.sv
// Bit-serial decoder for the four codes; one code bit per accepted word.
// Depends on ucc_pkg.
module ucc_decoder
  import ucc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  code_kind_t  code_kind,
  input  logic        clear,
  input  logic        take,
  input  logic        code_bit,
  output dec_result_t result
);

  logic [3:0] run_r, run_nxt;
  logic [5:0] bits_r, bits_nxt;
  logic [2:0] len_r, len_nxt;
  logic       pay_r, pay_nxt;
  logic       prev_r, prev_nxt;
  logic [5:0] shifted;
  logic [2:0] len_inc;
  logic [5:0] fib_sum;
  logic       restart;

  assign shifted = {bits_r[4:0], code_bit};
  assign len_inc = len_r + 3'd1;
  assign fib_sum = fib_value(bits_r);

  // Next decoder state and result for one code bit
  always_comb begin
    run_nxt  = run_r;
    bits_nxt = bits_r;
    len_nxt  = len_r;
    pay_nxt  = pay_r;
    prev_nxt = prev_r;
    restart  = 1'b0;
    result   = '0;
    unique case (code_kind)
      KIND_UNARY: begin
        if (code_bit) begin
          if (run_r >= 4'd14) begin
            restart    = 1'b1;
            result.err = 1'b1;
          end else begin
            run_nxt = run_r + 4'd1;
          end
        end else begin
          restart       = 1'b1;
          result.symbol = run_r + 4'd1;
          result.valid  = 1'b1;
        end
      end
      KIND_BINARY: begin
        if (len_r == 3'd3) begin
          restart = 1'b1;
          if (shifted[3:0] == 4'd0) result.err = 1'b1;
          else begin
            result.symbol = shifted[3:0];
            result.valid  = 1'b1;
          end
        end else begin
          bits_nxt = {2'b00, shifted[3:0]};
          len_nxt  = len_inc;
        end
      end
      KIND_GAMMA: begin
        if (!pay_r) begin
          if (!code_bit) begin
            if (run_r >= 4'd3) begin
              restart    = 1'b1;
              result.err = 1'b1;
            end else begin
              run_nxt = run_r + 4'd1;
            end
          end else if (run_r == 4'd0) begin
            restart       = 1'b1;
            result.symbol = 4'd1;
            result.valid  = 1'b1;
          end else begin
            pay_nxt  = 1'b1;
            bits_nxt = 6'd1;
            len_nxt  = 3'd1;
          end
        end else if ({1'b0, len_inc} < run_r + 4'd1) begin
          bits_nxt = shifted;
          len_nxt  = len_inc;
        end else begin
          restart       = 1'b1;
          result.symbol = shifted[3:0];
          result.valid  = 1'b1;
        end
      end
      KIND_FIB: begin
        if (code_bit && prev_r) begin
          restart = 1'b1;
          if (fib_sum > 6'd15) result.err = 1'b1;
          else begin
            result.symbol = fib_sum[3:0];
            result.valid  = 1'b1;
          end
        end else if (len_r >= 3'd6) begin
          restart    = 1'b1;
          result.err = 1'b1;
        end else begin
          bits_nxt = bits_r | (6'(code_bit) << len_r);
          len_nxt  = len_inc;
          prev_nxt = code_bit;
        end
      end
      default: result = '0;
    endcase
    if (result.err) result.valid = 1'b1;
  end

  // Hold state unless a bit is taken; drop it on restart or a register write
  always_ff @(posedge clk) begin
    if (!rst_n || clear || (take && restart)) begin
      run_r  <= 4'd0;
      bits_r <= 6'd0;
      len_r  <= 3'd0;
      pay_r  <= 1'b0;
      prev_r <= 1'b0;
    end else if (take) begin
      run_r  <= run_nxt;
      bits_r <= bits_nxt;
      len_r  <= len_nxt;
      pay_r  <= pay_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

### src/universal_code_codec.sv
// Top level of the universal code codec: config registers, encoder, decoder, output stage.
// Depends on ucc_pkg, ucc_encoder, ucc_decoder and universal_code_codec_defines.svh.
//
// Encodes symbols 1..15 into unary, 4-bit binary, Elias gamma or C1 Fibonacci
// codewords, or decodes a stream of code bits back into symbols, chosen by the
// code_kind and decode_mode registers (write them only while the block is idle;
// any write restarts the decoder). In encode mode a symbol is loaded into a
// codeword shift register and then leaves one bit per cycle while the output
// register is free; codewords are 1..15 bits for unary, 4 for binary, 1..7 for
// gamma and 2..7 for C1, and the next symbol is taken once the last bit has
// left. Symbol zero gives one error word. In decode mode one code bit is taken
// each cycle that the output register is free, and a result word appears when
// a codeword completes or is found invalid. Results sit in a single output
// register that refills in the cycle it is taken.
`include "universal_code_codec_defines.svh"
module universal_code_codec
  import ucc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_wdata,
  // input words
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_symbol_in,
  input  logic       in_code_bit,
  // result words
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_bit_out,
  output logic       out_bit_valid,
  output logic       out_last_bit,
  output logic [3:0] out_symbol_out,
  output logic       out_symbol_valid,
  output logic       out_code_error
);

  code_kind_t  code_kind_r;
  logic        decode_mode_r;
  logic        out_valid_r;
  logic        bit_out_r, bit_valid_r, last_bit_r, symbol_valid_r, code_error_r;
  logic [3:0]  symbol_out_r;
  logic        slot_free;
  logic        in_take;
  logic        enc_busy;
  logic        enc_emit;
  enc_word_t   enc_word;
  dec_result_t dec_res;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_kind_r   <= KIND_UNARY;
      decode_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODE_KIND:   code_kind_r   <= code_kind_t'(cfg_wdata);
        CFG_DECODE_MODE: decode_mode_r <= cfg_wdata[0];
        default:         code_kind_r   <= code_kind_r;
      endcase
    end
  end

  // Handshake: encode waits for the serializer, decode for the output slot
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = decode_mode_r ? !slot_free : enc_busy;
  assign in_take   = in_valid && !in_stall;
  assign enc_emit  = !decode_mode_r && enc_busy && slot_free;

  ucc_encoder u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .code_kind (code_kind_r),
    .load      (in_take && !decode_mode_r),
    .symbol    (in_symbol_in),
    .advance   (enc_emit),
    .busy      (enc_busy),
    .word      (enc_word)
  );

  ucc_decoder u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .code_kind (code_kind_r),
    .clear     (cfg_we),
    .take      (in_take && decode_mode_r),
    .code_bit  (in_code_bit),
    .result    (dec_res)
  );

  // Output register: fill from encoder or decoder, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (enc_emit || (in_take && decode_mode_r && dec_res.valid)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (enc_emit) begin
      bit_out_r      <= enc_word.code_bit;
      bit_valid_r    <= !enc_word.err;
      last_bit_r     <= enc_word.last;
      symbol_out_r   <= 4'd0;
      symbol_valid_r <= 1'b0;
      code_error_r   <= enc_word.err;
    end else if (in_take && decode_mode_r && dec_res.valid) begin
      bit_out_r      <= 1'b0;
      bit_valid_r    <= 1'b0;
      last_bit_r     <= 1'b1;
      symbol_out_r   <= dec_res.err ? 4'd0 : dec_res.symbol;
      symbol_valid_r <= !dec_res.err;
      code_error_r   <= dec_res.err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bit_out      = bit_out_r;
  assign out_bit_valid    = bit_valid_r;
  assign out_last_bit     = last_bit_r;
  assign out_symbol_out   = symbol_out_r;
  assign out_symbol_valid = symbol_valid_r;
  assign out_code_error   = code_error_r;

  `UCC_ASSERT_NOW(a_one_kind, out_valid_r, $onehot({bit_valid_r, symbol_valid_r, code_error_r}))
  `UCC_ASSERT_NOW(a_err_last, out_valid_r && code_error_r, last_bit_r && symbol_out_r == 4'd0)
  `UCC_ASSERT_NOW(a_sym_nonzero, out_valid_r && symbol_valid_r, symbol_out_r != 4'd0)
  `UCC_ASSERT_NOW(a_enc_blocks, !decode_mode_r && enc_busy, in_stall)

endmodule
